@@ rtl/core/lwe_encrypt_decrypt_mac_top_macros.svh @@
// Assertion macros for the LWE encrypt/decrypt MAC block.
// Included by the modules that carry concurrent checks; uses clk_i and rst_ni.
`ifndef LWE_ENCRYPT_DECRYPT_MAC_TOP_MACROS_SVH
`define LWE_ENCRYPT_DECRYPT_MAC_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define LWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LWE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LWE_ASSERT(lbl, prop, msg)
`define LWE_ASSERT_IMPL(lbl, ante, cons, msg)
`define LWE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/lwe_edm_pkg.sv @@
// Shared constants, codes and types of the LWE encrypt/decrypt MAC block.
// No dependencies.
`timescale 1ns / 1ps
package lwe_edm_pkg;

  localparam int unsigned KEY_LEN    = 1024;
  localparam int unsigned KEY_AW     = $clog2(KEY_LEN);
  localparam int unsigned COEFF_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned Q_W        = COEFF_BITS + 1;   // q may be 2^32
  localparam int unsigned DIV_W      = 2 * COEFF_BITS;   // dividend / quotient width
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam int unsigned DEC_W      = 48;
  localparam int unsigned MODE_W     = 2;

  // input tdata layout
  localparam int unsigned IDX_LSB    = 0;
  localparam int unsigned COEF_LSB   = IDX_LSB + KEY_AW;
  localparam int unsigned MSG_LSB    = COEF_LSB + COEFF_BITS;
  localparam int unsigned NOISE_LSB  = MSG_LSB + COEFF_BITS;
  localparam int unsigned BODY_LSB   = NOISE_LSB + COEFF_BITS;
  localparam int unsigned IN_RAW_W   = BODY_LSB + COEFF_BITS;
  localparam int unsigned IN_TDATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((COEFF_BITS + DEC_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_KEY       = 2'd0,
    MODE_ENC       = 2'd1,
    MODE_DEC       = 2'd2,
    MODE_ENC_PLAIN = 2'd3
  } mode_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [Q_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/lwe_edm_key_ram.sv @@
// Secret key store: single-port-write, registered-read memory.
// Depends on lwe_edm_pkg.
`timescale 1ns / 1ps
module lwe_edm_key_ram (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [lwe_edm_pkg::KEY_AW-1:0]     waddr_i,
  input  logic [lwe_edm_pkg::COEFF_BITS-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [lwe_edm_pkg::KEY_AW-1:0]     raddr_i,
  output logic [lwe_edm_pkg::COEFF_BITS-1:0] rdata_o
);
  import lwe_edm_pkg::*;

  logic [COEFF_BITS-1:0] mem_q [KEY_LEN];
  logic [COEFF_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lwe_edm_divider.sv @@
// Radix-2 restoring divider: 64-bit dividend by 33-bit divisor, one bit a cycle.
// Depends on lwe_edm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lwe_encrypt_decrypt_mac_top_macros.svh"
module lwe_edm_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lwe_edm_pkg::div_req_t           req_i,
  output lwe_edm_pkg::div_stat_t          stat_o,
  output logic [lwe_edm_pkg::DIV_W-1:0]   quotient_o,
  output logic [lwe_edm_pkg::Q_W-1:0]     remainder_o
);
  import lwe_edm_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [Q_W-1:0]       rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [Q_W-1:0]       dvs_q;

  logic [Q_W:0] trial, diff;
  logic         ge;

  // shift in next dividend bit, trial subtract
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `LWE_ASSERT_IMPL(a_div_start_idle, req_i.start, !busy_q, "divider restarted while busy")
  `LWE_ASSERT_NEXT(a_div_start_runs, req_i.start, busy_q, "divider did not start")
  `LWE_ASSERT_IMPL(a_div_done_on_fall, $fell(busy_q), done_q, "divider stopped without done")

endmodule

@@ rtl/core/lwe_encrypt_decrypt_mac_top.sv @@
// Top level of the LWE encrypt/decrypt MAC block: handshakes, sequencer, accumulator.
// Depends on lwe_edm_pkg, lwe_edm_key_ram, lwe_edm_divider and the macro header.
`timescale 1ns / 1ps
`include "lwe_encrypt_decrypt_mac_top_macros.svh"
// LWE symmetric encryption and decryption against a 1024-entry secret key held in
// an on-chip memory. Mode 0 items write one key word and return no result. Modes 1
// (encrypt, message scaled), 3 (encrypt, plain) and 2 (decrypt) stream mask
// elements; each adds a_i * s_i mod q into the accumulator. The element flagged by
// tlast returns one result item: the ciphertext body on encrypt, or the phase
// (b - sum) mod q plus phase * 2^16 / scale on decrypt (all ones if scale is 0).
// A modulus of 0 means q = 2^32. All reductions go through one shared radix-2
// divider; each takes 64 steps, so a mask element goes from its accept through a
// key read, a multiply and a reduction to the next ready. A last element adds two
// reductions on decrypt (one with scale 0), two reductions and an add on plain
// encrypt, or three reductions, a multiply and an add on scaled encrypt, and then
// loads the output register. Items are handled one at a time; the next item is
// taken while a result still waits in the output register. Key words never written
// read back as undefined. Configuration is to be written only between items; the
// block itself does not enforce this.
module lwe_encrypt_decrypt_mac_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // index[9:0], coefficient[41:10], message[73:42], noise[105:74], body[137:106], zero pad
  input  logic [lwe_edm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [lwe_edm_pkg::MODE_W-1:0]       s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // master stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_value[31:0], decoded_value[79:32]
  output logic [lwe_edm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [lwe_edm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lwe_edm_pkg::COEFF_BITS-1:0]   cfg_data_i
);
  import lwe_edm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_KEY        = 13'b0000000000010,  // key word on RAM output
    S_MUL        = 13'b0000000000100,  // product ready, start element reduction
    S_ELEM       = 13'b0000000001000,
    S_DEC_B      = 13'b0000000010000,  // phase reduction
    S_DEC_D      = 13'b0000000100000,  // phase / scale
    S_ENC_M      = 13'b0000001000000,  // |m| mod q
    S_ENC_MUL    = 13'b0000010000000,
    S_ENC_SCL_GO = 13'b0000100000000,
    S_ENC_SCL    = 13'b0001000000000,  // m*scale mod q
    S_ENC_ADD    = 13'b0010000000000,
    S_ENC_SUM    = 13'b0100000000000,  // m + e + sum mod q
    S_OUT        = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [COEFF_BITS-1:0] modulus_q, scale_q;
  logic [Q_W-1:0]        q_val;

  // captured item
  mode_e                   mode_q;
  logic [COEFF_BITS-1:0]   coef_q, noise_q, body_q;
  logic signed [COEFF_BITS-1:0] msg_q;
  logic                    last_q;

  // working registers
  logic [COEFF_BITS-1:0] acc_q, acc_d;
  logic [COEFF_BITS-1:0] sum_q, sum_d;
  logic [COEFF_BITS-1:0] m_q, m_d;
  logic [COEFF_BITS-1:0] res_q, res_d;
  logic [DEC_W-1:0]      dec_q, dec_d;
  logic [DIV_W-1:0]      prod_q, prod_d;

  // output register
  logic                  m_valid_q;
  logic [COEFF_BITS-1:0] out_res_q;
  logic [DEC_W-1:0]      out_dec_q;
  logic                  out_load;
  logic                  out_stall;

  // key memory
  logic                  key_we, key_re;
  logic [COEFF_BITS-1:0] key_rdata;

  // divider
  div_req_t              div_req;
  div_stat_t             div_stat;
  logic [DIV_W-1:0]      div_quo;
  logic [Q_W-1:0]        div_rem;

  // datapath helpers
  logic [COEFF_BITS-1:0] mul_a, mul_b;
  logic [DIV_W-1:0]      mul_p;
  logic                  msg_neg;
  logic [COEFF_BITS-1:0] msg_mag;
  logic [Q_W-1:0]        m_neg;
  logic [COEFF_BITS+1:0] ph_sum, enc_sum;
  logic                  in_accept;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign q_val = (modulus_q == '0) ? {1'b1, {COEFF_BITS{1'b0}}} : {1'b0, modulus_q};

  // one shared 32x32 multiplier, registered into prod_q
  assign mul_a = (state_q == S_KEY) ? coef_q    : m_q;
  assign mul_b = (state_q == S_KEY) ? key_rdata : scale_q;
  assign mul_p = DIV_W'(mul_a) * DIV_W'(mul_b);

  // |m|, then fold negative back: q - (|m| mod q)
  assign msg_neg = (msg_q < 0);
  assign msg_mag = msg_neg ? $unsigned(-msg_q) : $unsigned(msg_q);
  assign m_neg   = q_val - div_rem;

  assign ph_sum  = {2'b00, body_q} + {1'b0, q_val} - {1'b0, div_rem};
  assign enc_sum = {2'b00, m_q} + {2'b00, noise_q} + {2'b00, sum_q};

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '1;
      scale_q   <= COEFF_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODULUS: modulus_q <= cfg_data_i;
        CFG_SCALE:   scale_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q  <= mode_e'(s_axis_tuser);
      coef_q  <= s_axis_tdata[COEF_LSB +: COEFF_BITS];
      msg_q   <= $signed(s_axis_tdata[MSG_LSB +: COEFF_BITS]);
      noise_q <= s_axis_tdata[NOISE_LSB +: COEFF_BITS];
      body_q  <= s_axis_tdata[BODY_LSB +: COEFF_BITS];
      last_q  <= s_axis_tlast;
    end
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    acc_d            = acc_q;
    sum_d            = sum_q;
    m_d              = m_q;
    res_d            = res_q;
    dec_d            = dec_q;
    prod_d           = prod_q;
    key_we           = 1'b0;
    key_re           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = q_val;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (mode_e'(s_axis_tuser) == MODE_KEY) begin
            key_we = 1'b1;
          end else begin
            key_re  = 1'b1;
            state_d = S_KEY;
          end
        end
      end
      S_KEY: begin
        prod_d  = mul_p;
        state_d = S_MUL;
      end
      S_MUL: begin
        // (acc + a*s) mod q; sum stays below 2^64
        div_req.start    = 1'b1;
        div_req.dividend = prod_q + DIV_W'(acc_q);
        state_d          = S_ELEM;
      end
      S_ELEM: begin
        if (div_stat.done) begin
          if (!last_q) begin
            acc_d   = div_rem[COEFF_BITS-1:0];
            state_d = S_IDLE;
          end else begin
            acc_d         = '0;
            sum_d         = div_rem[COEFF_BITS-1:0];
            div_req.start = 1'b1;
            if (mode_q == MODE_DEC) begin
              div_req.dividend = DIV_W'(ph_sum);
              state_d          = S_DEC_B;
            end else begin
              div_req.dividend = DIV_W'(msg_mag);
              state_d          = S_ENC_M;
            end
          end
        end
      end
      S_DEC_B: begin
        if (div_stat.done) begin
          res_d = div_rem[COEFF_BITS-1:0];
          if (scale_q == '0) begin
            dec_d   = '1;
            state_d = S_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({div_rem[COEFF_BITS-1:0], {FRAC_BITS{1'b0}}});
            div_req.divisor  = {1'b0, scale_q};
            state_d          = S_DEC_D;
          end
        end
      end
      S_DEC_D: begin
        if (div_stat.done) begin
          dec_d   = div_quo[DEC_W-1:0];
          state_d = S_OUT;
        end
      end
      S_ENC_M: begin
        if (div_stat.done) begin
          m_d     = (msg_neg && (div_rem != '0)) ? m_neg[COEFF_BITS-1:0]
                                                 : div_rem[COEFF_BITS-1:0];
          state_d = (mode_q == MODE_ENC) ? S_ENC_MUL : S_ENC_ADD;
        end
      end
      S_ENC_MUL: begin
        prod_d  = mul_p;
        state_d = S_ENC_SCL_GO;
      end
      S_ENC_SCL_GO: begin
        div_req.start = 1'b1;
        state_d       = S_ENC_SCL;
      end
      S_ENC_SCL: begin
        if (div_stat.done) begin
          m_d     = div_rem[COEFF_BITS-1:0];
          state_d = S_ENC_ADD;
        end
      end
      S_ENC_ADD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(enc_sum);
        state_d          = S_ENC_SUM;
      end
      S_ENC_SUM: begin
        if (div_stat.done) begin
          res_d   = div_rem[COEFF_BITS-1:0];
          dec_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    m_q    <= m_d;
    res_q  <= res_d;
    dec_q  <= dec_d;
    prod_q <= prod_d;
    if (out_load) begin
      out_res_q <= res_q;
      out_dec_q <= dec_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_dec_q, out_res_q});

  // result waiting while the output register is still full
  assign out_stall = (state_q == S_OUT) && m_valid_q && !m_axis_tready;

  lwe_edm_key_ram u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (s_axis_tdata[IDX_LSB +: KEY_AW]),
    .wdata_i (s_axis_tdata[COEF_LSB +: COEFF_BITS]),
    .re_i    (key_re),
    .raddr_i (s_axis_tdata[IDX_LSB +: KEY_AW]),
    .rdata_o (key_rdata)
  );

  lwe_edm_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  `LWE_ASSERT_IMPL(a_idle_div_free, s_axis_tready, !div_stat.busy, "idle with divider running")
  `LWE_ASSERT_NEXT(a_key_read_next, key_re, state_q == S_KEY, "key read not followed by use")
  `LWE_ASSERT_NEXT(a_out_wait, out_stall, state_q == S_OUT, "result dropped while output busy")

endmodule

@@ sim/tb_lwe_encrypt_decrypt_mac_top.sv @@
// Self-checking testbench for lwe_encrypt_decrypt_mac_top: directed table, then random phases.
// Depends on lwe_edm_pkg and the RTL of the block; the predictor below is written locally.
`timescale 1ns / 1ps
module tb_lwe_encrypt_decrypt_mac_top;
  import lwe_edm_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  // Time given to any item in flight to finish before a register write or the
  // final verdict.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 4000;
  localparam int PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [63:0] DEC_ALL_ONES = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] TWO_POW_32   = 64'h1_0000_0000;

  // one input item, as the block sees it
  typedef struct packed {
    mode_e                 mode;
    logic [KEY_AW-1:0]     index;
    logic [COEFF_BITS-1:0] coef;
    logic [COEFF_BITS-1:0] msg;
    logic [COEFF_BITS-1:0] noise;
    logic [COEFF_BITS-1:0] body;
    logic                  last;
  } lwe_item_t;

  // result item, laid out as in m_axis_tdata (result_value in the low bits)
  typedef struct packed {
    logic [DEC_W-1:0]      dec;
    logic [COEFF_BITS-1:0] res;
  } lwe_result_t;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [COEFF_BITS-1:0] reg_val;
    lwe_item_t             item;
    logic                  typed;   // expectation typed in below
    lwe_result_t           want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [COEFF_BITS-1:0]  cfg_data_i    = '0;

  // local copy of the block's state and registers
  logic [COEFF_BITS-1:0] key_copy [KEY_LEN];
  logic [COEFF_BITS-1:0] acc_copy     = '0;
  logic [COEFF_BITS-1:0] modulus_copy = 32'hFFFF_FFFF;
  logic [COEFF_BITS-1:0] scale_copy   = 32'd1;

  // key entries written so far; mask elements only ever address these
  bit                key_written [KEY_LEN];
  logic [KEY_AW-1:0] written_list [$];

  lwe_result_t awaited_results [$];
  int errors      = 0;
  int cycle_count = 0;
  int snd_idle_pct = 20;
  int rcv_idle_pct = 47;
  int hold_left    = 0;

  lwe_encrypt_decrypt_mac_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Modular helpers: operands already below q <= 2^32, so 64 bits suffice.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
    return (a * b) % q;
  endfunction

  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
    logic [63:0] s;
    s = a + b;
    return (s >= q) ? s - q : s;
  endfunction

  // Predictor: updates the local state for one item, returns 1 with the result
  // when the item closes a vector in an encrypt or decrypt mode.
  function automatic bit lwe_compute(input lwe_item_t it, output lwe_result_t r);
    logic [63:0] q, acc, m, b, ph, dec, mag;
    r = '0;
    q = (modulus_copy == '0) ? TWO_POW_32 : {32'd0, modulus_copy};
    if (it.mode == MODE_KEY) begin
      key_copy[it.index] = it.coef;
      return 1'b0;
    end
    acc = add_mod({32'd0, acc_copy} % q,
                  mul_mod({32'd0, it.coef} % q, {32'd0, key_copy[it.index]} % q, q), q);
    if (!it.last) begin
      acc_copy = acc[COEFF_BITS-1:0];
      return 1'b0;
    end
    acc_copy = '0;
    if (it.mode == MODE_DEC) begin
      b  = {32'd0, it.body} % q;
      ph = (b >= acc) ? b - acc : b + (q - acc);
      if (scale_copy == '0) begin
        dec = DEC_ALL_ONES;
      end else begin
        dec = (ph << FRAC_BITS) / {32'd0, scale_copy};
        if (dec > DEC_ALL_ONES) dec = DEC_ALL_ONES;
      end
    end else begin
      // signed message folded fully into [0, q)
      mag = it.msg[31] ? (TWO_POW_32 - {32'd0, it.msg}) : {32'd0, it.msg};
      m   = mag % q;
      if (it.msg[31] && m != 0) m = q - m;
      if (it.mode == MODE_ENC) m = mul_mod(m, {32'd0, scale_copy} % q, q);
      ph  = add_mod(add_mod(m, {32'd0, it.noise} % q, q), acc, q);
      dec = '0;
    end
    r.res = ph[COEFF_BITS-1:0];
    r.dec = dec[DEC_W-1:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [COEFF_BITS-1:0] val);
    step_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic step_row_t item_row(mode_e mode, logic [KEY_AW-1:0] idx,
                                         logic [31:0] coef, logic [31:0] msg,
                                         logic [31:0] noise, logic [31:0] body, logic last);
    step_row_t r;
    r = '0;
    r.item.mode  = mode;
    r.item.index = idx;
    r.item.coef  = coef;
    r.item.msg   = msg;
    r.item.noise = noise;
    r.item.body  = body;
    r.item.last  = last;
    return r;
  endfunction

  function automatic step_row_t typed_row(step_row_t r, logic [31:0] res, logic [47:0] dec);
    r.typed    = 1'b1;
    r.want.res = res;
    r.want.dec = dec;
    return r;
  endfunction

  // operand with a bias towards the edges of the word and of q
  function automatic logic [31:0] draw_word();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return (modulus_copy == '0) ? 32'hFFFF_FFFF : modulus_copy - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream driver: data changes at the falling edge, handshake seen at the
  // rising edge. Returns just after the edge that took the item.
  // ---------------------------------------------------------------------------
  task automatic push_item(input lwe_item_t it, input logic typed, input lwe_result_t want);
    logic [IN_TDATA_W-1:0] word;
    lwe_result_t predicted;
    word = '0;
    word[IDX_LSB   +: KEY_AW]     = it.index;
    word[COEF_LSB  +: COEFF_BITS] = it.coef;
    word[MSG_LSB   +: COEFF_BITS] = it.msg;
    word[NOISE_LSB +: COEFF_BITS] = it.noise;
    word[BODY_LSB  +: COEFF_BITS] = it.body;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= it.mode;
    s_axis_tlast  <= it.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.mode == MODE_KEY && !key_written[it.index]) begin
      key_written[it.index] = 1'b1;
      written_list.push_back(it.index);
    end
    if (lwe_compute(it, predicted)) awaited_results.push_back(typed ? want : predicted);
  endtask

  // Sender stops, all results drain, and any result-less item still being
  // worked on gets time to finish.
  task automatic settle_block();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_BITS-1:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_MODULUS) modulus_copy = val;
    else scale_copy = val;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, or a long hold-off when asked for
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    lwe_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[COEFF_BITS+DEC_W-1:0];
      if (awaited_results.size() == 0) begin
        $display("%0t: result item with nothing expected, expected none, got res=%h dec=%h",
                 $time, got.res, got.dec);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (got.res !== want.res) begin
          $display("%0t: result_value mismatch, expected %h, got %h", $time, want.res, got.res);
          errors++;
        end
        if (got.dec !== want.dec) begin
          $display("%0t: decoded_value mismatch, expected %h, got %h", $time, want.dec, got.dec);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    step_row_t   script [$];
    lwe_item_t   it;
    lwe_result_t none;
    int          sent, len;
    logic [31:0] mod_val, scale_val;

    none = '0;

    // Directed part. Starts from the reset registers: q = 2^32 - 1, scale = 1.
    script.push_back(item_row(MODE_KEY, 10'd0,     32'h0000_0000, 0, 0, 0, 1'b0));
    // key write flagged last: no result
    script.push_back(item_row(MODE_KEY, 10'd1023,  32'hFFFF_FFFF, 0, 0, 0, 1'b1));
    script.push_back(item_row(MODE_KEY, 10'h155,   32'h1234_5678, 0, 0, 0, 1'b0));
    script.push_back(item_row(MODE_KEY, 10'h2AA,   32'hFFFF_FFFE, 0, 0, 0, 1'b0));
    // key 0 is zero, so the body is message plus noise
    script.push_back(typed_row(item_row(MODE_ENC_PLAIN, 10'd0, 32'hFFFF_FFFF, 32'd5, 0, 0, 1'b1),
                               32'd5, 48'd0));
    // negative message folds to q - 1; key 2^32-1 reduces to zero
    script.push_back(typed_row(item_row(MODE_ENC, 10'd1023, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                                        0, 0, 1'b1), 32'hFFFF_FFFE, 48'd0));
    script.push_back(typed_row(item_row(MODE_DEC, 10'd0, 32'h0000_1234, 0, 0, 32'd7, 1'b1),
                               32'd7, 48'h0000_0007_0000));
    script.push_back(typed_row(item_row(MODE_DEC, 10'd0, 0, 0, 0, 32'hFFFF_FFFE, 1'b1),
                               32'hFFFF_FFFE, 48'hFFFF_FFFE_0000));
    script.push_back(item_row(MODE_ENC_PLAIN, 10'd0, 0, 32'h8000_0000, 32'hFFFF_FFFE, 0, 1'b1));
    script.push_back(item_row(MODE_ENC, 10'h155, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 0, 1'b1));
    // mixed modes in one vector, with a key write flagged last in the middle
    script.push_back(item_row(MODE_ENC, 10'h155, 32'hDEAD_BEEF, 0, 0, 0, 1'b0));
    script.push_back(item_row(MODE_DEC, 10'h2AA, 32'h0FED_CBA9, 0, 0, 32'h1111_1111, 1'b0));
    script.push_back(item_row(MODE_KEY, 10'd5,   32'hCAFE_F00D, 0, 0, 0, 1'b1));
    script.push_back(item_row(MODE_ENC_PLAIN, 10'd5, 32'h1357_9BDF, 32'd3, 32'd4, 0, 1'b1));
    // scale zero: decoded value saturates
    script.push_back(reg_row(CFG_SCALE, 32'd0));
    script.push_back(typed_row(item_row(MODE_DEC, 10'd0, 0, 0, 0, 32'd3, 1'b1),
                               32'd3, 48'hFFFF_FFFF_FFFF));
    // modulus one: everything collapses to zero
    script.push_back(reg_row(CFG_SCALE, 32'hFFFF_FFFF));
    script.push_back(reg_row(CFG_MODULUS, 32'd1));
    script.push_back(typed_row(item_row(MODE_ENC, 10'h155, 32'hDEAD_BEEF, 32'hFFFF_FFF9,
                                        32'd9, 0, 1'b1), 32'd0, 48'd0));
    script.push_back(typed_row(item_row(MODE_DEC, 10'h2AA, 32'd1, 0, 0, 32'hFFFF_FFFE, 1'b1),
                               32'd0, 48'd0));
    // modulus zero stands for 2^32
    script.push_back(reg_row(CFG_MODULUS, 32'd0));
    script.push_back(typed_row(item_row(MODE_ENC_PLAIN, 10'd0, 0, 32'hFFFF_FFFF, 0, 0, 1'b1),
                               32'hFFFF_FFFF, 48'd0));
    script.push_back(typed_row(item_row(MODE_DEC, 10'd0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1),
                               32'hFFFF_FFFF, 48'h0000_0001_0000));
    // modulus changed while a vector is open
    script.push_back(item_row(MODE_ENC, 10'h155, 32'hDEAD_BEEF, 0, 0, 0, 1'b0));
    script.push_back(reg_row(CFG_MODULUS, 32'd2));
    script.push_back(item_row(MODE_ENC, 10'h2AA, 32'd3, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1'b1));

    // reset held from the start, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle_block();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        push_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    // Random phases: each picks a register setting, then streams vectors
    // of mask elements over written keys, with stray key writes mixed in.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0:       mod_val = 32'hFFFF_FFFF;
        1, 10:   mod_val = 32'd0;
        3:       mod_val = 32'd2;
        4:       mod_val = 32'd1;
        5:       mod_val = $urandom_range(2, 16'hFFFF);
        6:       mod_val = 32'h8000_0000;
        8:       mod_val = 32'd3;
        11:      mod_val = 32'hFFFF_FFFE;
        default: mod_val = $urandom_range(2, 32'hFFFF_FFFF);
      endcase
      case (phase % 6)
        0:       scale_val = 32'd1;
        2:       scale_val = 32'hFFFF_FFFF;
        3:       scale_val = 32'd0;
        4:       scale_val = $urandom_range(1, 255);
        default: scale_val = $urandom();
      endcase
      write_reg(CFG_MODULUS, mod_val);
      write_reg(CFG_SCALE, scale_val);

      if (phase < 4) begin
        snd_idle_pct = 20;
        rcv_idle_pct = 47;
      end else if (phase < 8) begin
        snd_idle_pct = 47;
        rcv_idle_pct = 20;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long receiver hold-off while the sender keeps offering items
      if (phase == 1) hold_left = HOLD_CYCLES;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 8) begin
          it.mode  = MODE_KEY;
          it.index = KEY_AW'($urandom_range(KEY_LEN - 1));
          it.coef  = draw_word();
          it.msg   = $urandom();
          it.noise = $urandom();
          it.body  = $urandom();
          it.last  = 1'($urandom_range(1));
          push_item(it, 1'b0, none);
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int e = 0; e < len; e++) begin
            if ($urandom_range(99) < 4) begin
              // stray key write inside an open vector
              it.mode  = MODE_KEY;
              it.index = written_list[$urandom_range(written_list.size() - 1)];
              it.coef  = draw_word();
              it.last  = 1'($urandom_range(1));
              push_item(it, 1'b0, none);
              sent++;
            end
            it.mode  = mode_e'($urandom_range(1, 3));
            it.index = written_list[$urandom_range(written_list.size() - 1)];
            it.coef  = draw_word();
            it.msg   = draw_word();
            it.noise = draw_word();
            it.body  = draw_word();
            it.last  = (e == len - 1);
            push_item(it, 1'b0, none);
            sent++;
          end
        end
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
